@@ src/qclt_pkg.sv @@
// Shared types and constants of the quoted command line tokenizer.
`default_nettype none

package qclt_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam logic [9:0] LIMIT_RESET = 10'd512;
   localparam logic [7:0] COUNT_MAX = 8'd255;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;

   localparam logic [1:0] STATUS_NONE  = 2'd0;
   localparam logic [1:0] STATUS_QUOTE = 2'd1;
   localparam logic [1:0] STATUS_EOL   = 2'd2;

   typedef enum logic [2:0] {
      CLS_BLANK,
      CLS_EOL,
      CLS_COMMENT,
      CLS_QUOTE,
      CLS_OTHER
   } cls_type;

   // One classified item waiting between the front and the back.
   typedef struct packed {
      logic [7:0] ch;
      cls_type    cls;
      logic       line_start;
   } entry_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_out;
      logic       token_begin;
      logic       token_end;
      logic       truncated;
      logic       line_done;
      logic [1:0] status;
      logic [7:0] token_count;
   } result_type;

   function automatic cls_type classify(input logic [7:0] ch);
      cls_type cls;
      case (ch)
         CH_LF, CH_CR, CH_NUL: cls = CLS_EOL;
         CH_TAB, CH_SPACE:     cls = CLS_BLANK;
         CH_BANG, CH_HASH:     cls = CLS_COMMENT;
         CH_DQUOTE:            cls = CLS_QUOTE;
         default:              cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

endpackage

`default_nettype wire

@@ src/qclt_ifs.sv @@
// Channel interfaces of the quoted command line tokenizer.
`default_nettype none

interface qclt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       line_start;
   modport source (output valid, char_in, line_start, input ready);
   modport sink   (input valid, char_in, line_start, output ready);
endinterface

interface qclt_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [7:0] char_out;
   logic       token_begin;
   logic       token_end;
   logic       truncated;
   logic       line_done;
   logic [1:0] status;
   logic [7:0] token_count;
   modport source (output valid, char_valid, char_out, token_begin, token_end,
                   truncated, line_done, status, token_count, input ready);
   modport sink   (input valid, char_valid, char_out, token_begin, token_end,
                   truncated, line_done, status, token_count, output ready);
endinterface

interface qclt_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] token_limit;
   modport source (output valid, token_limit, input ready);
   modport sink   (input valid, token_limit, output ready);
endinterface

`default_nettype wire

@@ src/qclt_queue.sv @@
// Short queue of classified items between the front and the back.
`default_nettype none

module qclt_queue
   import qclt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  entry_type      push_data,
   output logic           push_ready,
   input  wire logic      pop,
   output entry_type      pop_data,
   output logic           pop_valid
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ src/qclt_front.sv @@
// Front end: accepts characters and classifies them for the queue.
`default_nettype none

module qclt_front
   import qclt_pkg::*;
(
   qclt_req_if.sink  req,
   output logic      push,
   output entry_type push_data,
   input  wire logic push_ready
);

   assign req.ready            = push_ready;
   assign push                 = req.valid;
   assign push_data.ch         = req.char_in;
   assign push_data.cls        = classify(req.char_in);
   assign push_data.line_start = req.line_start;

endmodule

`default_nettype wire

@@ src/qclt_back.sv @@
// Back end: scan state machine, token counting and the result register.
`default_nettype none

module qclt_back
   import qclt_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = 512
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  pop_valid,
   input  entry_type  pop_data,
   output logic       pop,
   qclt_csr_if.sink   csr,
   qclt_rsp_if.source rsp
);

   typedef enum logic [1:0] {
      MODE_BLANK  = 2'd0,
      MODE_WORD   = 2'd1,
      MODE_QUOTED = 2'd2
   } mode_type;

   localparam logic [12:0] MaxLen = 13'(MAX_TOKEN_LEN);

   mode_type    mode_ff, mode_in;
   logic [9:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic        active_ff, active_in;
   logic [1:0]  error_ff, error_in;
   logic [9:0]  limit_ff;
   logic        rsp_valid_ff;
   result_type  res_ff, res_in;

   logic        add, finish, stop, keep;
   logic [9:0]  len_cur;

   assign pop       = pop_valid && (!rsp_valid_ff || rsp.ready);
   assign csr.ready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      length_in = length_ff;
      count_in  = count_ff;
      active_in = active_ff;
      error_in  = error_ff;
      add       = 1'b0;
      finish    = 1'b0;
      stop      = 1'b0;
      keep      = 1'b0;
      res_in    = '0;

      // A line start clears the line state before the character is scanned.
      if (pop_data.line_start) begin
         mode_in   = MODE_BLANK;
         length_in = '0;
         count_in  = '0;
         active_in = 1'b1;
         error_in  = STATUS_NONE;
      end

      if (active_in) begin
         case (mode_in)
            MODE_WORD: begin
               case (pop_data.cls)
                  CLS_BLANK: begin
                     finish  = 1'b1;
                     mode_in = MODE_BLANK;
                  end
                  CLS_EOL: begin
                     finish           = 1'b1;
                     stop             = 1'b1;
                     res_in.line_done = 1'b1;
                  end
                  CLS_COMMENT: begin
                     stop             = 1'b1;
                     res_in.line_done = 1'b1;
                  end
                  CLS_QUOTE: begin
                     stop     = 1'b1;
                     error_in = STATUS_QUOTE;
                  end
                  default: add = 1'b1;
               endcase
            end
            MODE_QUOTED: begin
               case (pop_data.cls)
                  CLS_EOL: begin
                     stop     = 1'b1;
                     error_in = STATUS_EOL;
                  end
                  CLS_QUOTE: begin
                     finish  = 1'b1;
                     mode_in = MODE_BLANK;
                  end
                  default: add = 1'b1;
               endcase
            end
            default: begin
               case (pop_data.cls)
                  CLS_BLANK: ;
                  CLS_EOL, CLS_COMMENT: begin
                     stop             = 1'b1;
                     res_in.line_done = 1'b1;
                  end
                  CLS_QUOTE: begin
                     // An opening quote starts an empty token.
                     mode_in            = MODE_QUOTED;
                     length_in          = '0;
                     res_in.token_begin = 1'b1;
                  end
                  default: begin
                     mode_in            = MODE_WORD;
                     length_in          = '0;
                     res_in.token_begin = 1'b1;
                     add                = 1'b1;
                  end
               endcase
            end
         endcase
      end

      len_cur = length_in;
      keep    = ({3'b000, len_cur} < {3'b000, limit_ff}) && ({3'b000, len_cur} < MaxLen);
      if (add) begin
         if (keep) begin
            res_in.char_valid = 1'b1;
            res_in.char_out   = pop_data.ch;
            length_in         = len_cur + 10'd1;
         end else begin
            res_in.truncated = 1'b1;
         end
      end
      if (finish) begin
         res_in.token_end = 1'b1;
         if (count_in != COUNT_MAX) begin
            count_in = count_in + 8'd1;
         end
      end
      if (stop) begin
         active_in = 1'b0;
         mode_in   = MODE_BLANK;
      end

      res_in.status      = error_in;
      res_in.token_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BLANK;
         length_ff    <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         error_ff     <= STATUS_NONE;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            limit_ff <= csr.token_limit;
         end
         if (pop) begin
            mode_ff   <= mode_in;
            length_ff <= length_in;
            count_ff  <= count_in;
            active_ff <= active_in;
            error_ff  <= error_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.char_valid  = res_ff.char_valid;
   assign rsp.char_out    = res_ff.char_out;
   assign rsp.token_begin = res_ff.token_begin;
   assign rsp.token_end   = res_ff.token_end;
   assign rsp.truncated   = res_ff.truncated;
   assign rsp.line_done   = res_ff.line_done;
   assign rsp.status      = res_ff.status;
   assign rsp.token_count = res_ff.token_count;

   // An idle line always rests in blank mode.
   assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> mode_ff == MODE_BLANK)
      else $error("idle line not in blank mode");

   // A kept byte and a dropped byte never come from the same item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(res_ff.char_valid && res_ff.truncated))
      else $error("byte both kept and dropped");

   // A clean line end never carries an error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.line_done |-> res_ff.status == STATUS_NONE)
      else $error("line done with error status");

   // Within a line the token count never falls.
   assert property (@(posedge clock) disable iff (reset)
      pop && !pop_data.line_start |=> count_ff >= $past(count_ff))
      else $error("token count decreased within a line");

   // The result register is loaded whenever an item leaves the queue.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped item produced no result");

endmodule

`default_nettype wire

@@ src/quoted_command_line_tokenizer.sv @@
// Top level of the quoted command line tokenizer.
//
//   Channel  Dir  Handshake            Item contents
//   req      in   req.valid/req.ready  char_in, line_start
//   rsp      out  rsp.valid/rsp.ready  char_valid, char_out, token_begin, token_end,
//                                      truncated, line_done, status, token_count
//   csr      in   csr.valid/csr.ready  token_limit (always ready)
//
// One item is accepted per cycle while the queue has room and gives one result.
// The rate is set by the scan state machine in the back end, which updates once per item.
// A two-entry queue and the result register let either side stall independently.
// Synchronous reset clears the scan state, the queue and the result valid flag and sets
// token_limit to 512; no line is active until an item with line_start arrives.
`default_nettype none

module quoted_command_line_tokenizer
   import qclt_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = 512
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   qclt_req_if.sink   req,
   qclt_rsp_if.source rsp,
   qclt_csr_if.sink   csr
);

   logic      push, push_ready, pop, pop_valid;
   entry_type push_data, pop_data;

   qclt_front u_front (
      .req        (req),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   qclt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid)
   );

   qclt_back #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .csr       (csr),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench of the quoted command line tokenizer: directed and random lines against a predictor.
`timescale 1ns / 1ps

module tb
   import qclt_pkg::*;
();

   localparam int MAX_TOKEN_LEN = 512;
   localparam int QUIET_LIMIT = 1000;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int TAIL_CYCLES = 10;

   typedef enum logic [1:0] {SCAN_BLANK, SCAN_WORD, SCAN_QUOTED} scan_type;
   typedef enum {LINE_PLAIN, LINE_LONG_WORD, LINE_MANY_TOKENS} opening_type;

   typedef struct packed {
      logic       typed;
      result_type want;
   } pin_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       ls;
      logic       typed;
      result_type want;
   } script_row_type;

   // Rows with typed set carry their result; the others are predicted.
   localparam script_row_type SCRIPT [25] = '{
      '{8'h61, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, STATUS_NONE, 8'd0}},
      '{CH_SPACE, 1'b1, 1'b0, '0},
      '{8'h78, 1'b0, 1'b0, '0},
      '{CH_TAB, 1'b0, 1'b0, '0},
      // An empty quoted string, then one that keeps a blank and a comment byte.
      '{CH_DQUOTE, 1'b0, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, 1'b0, '0},
      '{CH_SPACE, 1'b0, 1'b0, '0},
      '{CH_HASH, 1'b0, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, 1'b0, '0},
      // A comment inside a bare word ends the line and drops the word.
      '{8'h62, 1'b0, 1'b0, '0},
      '{CH_BANG, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, STATUS_NONE, 8'd3}},
      '{8'h63, 1'b0, 1'b0, '0},
      '{8'h77, 1'b1, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, STATUS_QUOTE, 8'd0}},
      '{8'h7A, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, STATUS_QUOTE, 8'd0}},
      '{CH_DQUOTE, 1'b1, 1'b0, '0},
      '{CH_NUL, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, STATUS_EOL, 8'd0}},
      '{CH_CR, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, STATUS_NONE, 8'd0}},
      '{8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, STATUS_NONE, 8'd0}},
      '{CH_LF, 1'b0, 1'b0, '0},
      '{CH_BANG, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, STATUS_NONE, 8'd0}},
      '{8'h80, 1'b1, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{CH_CR, 1'b0, 1'b0, '0}
   };

   logic clock;
   logic reset;

   qclt_req_if req_ch ();
   qclt_rsp_if rsp_ch ();
   qclt_csr_if csr_ch ();

   quoted_command_line_tokenizer #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Predictor state.
   logic [9:0] limit_shadow = LIMIT_RESET;
   scan_type   scan_state = SCAN_BLANK;
   logic [9:0] kept_len = '0;
   logic [7:0] token_tally = '0;
   logic       line_open = 1'b0;
   logic [1:0] line_error = STATUS_NONE;

   result_type awaited_outputs [$];
   pin_type    pinned_outputs [$];
   logic [7:0] line_buf [$];

   int  parsed_chars = 0;
   int  error_count = 0;
   int  results_seen = 0;
   int  quiet_cycles = 0;
   int  send_idle_pct = 25;
   int  rcv_idle_pct = 46;
   bit  rsp_hold_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic cls_type char_class(input logic [7:0] ch);
      cls_type c;
      case (ch)
         CH_LF, CH_CR, CH_NUL: c = CLS_EOL;
         CH_TAB, CH_SPACE:     c = CLS_BLANK;
         CH_BANG, CH_HASH:     c = CLS_COMMENT;
         CH_DQUOTE:            c = CLS_QUOTE;
         default:              c = CLS_OTHER;
      endcase
      return c;
   endfunction

   function automatic result_type tokenize_char(input logic [7:0] ch, input logic ls);
      result_type r;
      cls_type    c;
      logic       add;
      logic       finish;
      logic       stop;
      logic [9:0] cap;
      r = '0;
      if (ls) begin
         scan_state = SCAN_BLANK;
         kept_len = '0;
         token_tally = '0;
         line_open = 1'b1;
         line_error = STATUS_NONE;
      end
      if (line_open) begin
         parsed_chars++;
         c = char_class(ch);
         add = 1'b0;
         finish = 1'b0;
         stop = 1'b0;
         case (scan_state)
            SCAN_WORD: begin
               case (c)
                  CLS_BLANK: begin
                     finish = 1'b1;
                     scan_state = SCAN_BLANK;
                  end
                  CLS_EOL: begin
                     finish = 1'b1;
                     stop = 1'b1;
                     r.line_done = 1'b1;
                  end
                  CLS_COMMENT: begin
                     stop = 1'b1;
                     r.line_done = 1'b1;
                  end
                  CLS_QUOTE: begin
                     stop = 1'b1;
                     line_error = STATUS_QUOTE;
                  end
                  default: add = 1'b1;
               endcase
            end
            SCAN_QUOTED: begin
               case (c)
                  CLS_EOL: begin
                     stop = 1'b1;
                     line_error = STATUS_EOL;
                  end
                  CLS_QUOTE: begin
                     finish = 1'b1;
                     scan_state = SCAN_BLANK;
                  end
                  default: add = 1'b1;
               endcase
            end
            default: begin
               case (c)
                  CLS_BLANK: ;
                  CLS_EOL, CLS_COMMENT: begin
                     stop = 1'b1;
                     r.line_done = 1'b1;
                  end
                  CLS_QUOTE: begin
                     scan_state = SCAN_QUOTED;
                     kept_len = '0;
                     r.token_begin = 1'b1;
                  end
                  default: begin
                     scan_state = SCAN_WORD;
                     kept_len = '0;
                     r.token_begin = 1'b1;
                     add = 1'b1;
                  end
               endcase
            end
         endcase
         cap = (limit_shadow > MAX_TOKEN_LEN) ? 10'(MAX_TOKEN_LEN) : limit_shadow;
         if (add) begin
            if (kept_len < cap) begin
               r.char_valid = 1'b1;
               r.char_out = ch;
               kept_len = kept_len + 10'd1;
            end else begin
               r.truncated = 1'b1;
            end
         end
         if (finish) begin
            r.token_end = 1'b1;
            if (token_tally != COUNT_MAX) token_tally = token_tally + 8'd1;
         end
         if (stop) begin
            line_open = 1'b0;
            scan_state = SCAN_BLANK;
         end
      end
      r.status = line_error;
      r.token_count = token_tally;
      return r;
   endfunction

   task automatic log_failure(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         log_failure($sformatf("result %0d field %s got %0h want %0h",
                               results_seen, name, got, want));
   endtask

   // Sampling happens on pre-edge values, so the order of processes within a step is irrelevant.
   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      pin_type    pin;
      bit         busy;
      busy = 1'b0;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            limit_shadow = csr_ch.token_limit;
            busy = 1'b1;
         end
         if (req_ch.valid && req_ch.ready) begin
            want = tokenize_char(req_ch.char_in, req_ch.line_start);
            if (pinned_outputs.size() != 0) begin
               pin = pinned_outputs.pop_front();
               if (pin.typed) want = pin.want;
            end
            awaited_outputs.push_back(want);
            busy = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.char_valid, rsp_ch.char_out, rsp_ch.token_begin, rsp_ch.token_end,
                    rsp_ch.truncated, rsp_ch.line_done, rsp_ch.status, rsp_ch.token_count};
            busy = 1'b1;
            results_seen++;
            if (awaited_outputs.size() == 0) begin
               log_failure($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want = awaited_outputs.pop_front();
               check_field("char_valid", 8'(got.char_valid), 8'(want.char_valid));
               check_field("char_out", got.char_out, want.char_out);
               check_field("token_begin", 8'(got.token_begin), 8'(want.token_begin));
               check_field("token_end", 8'(got.token_end), 8'(want.token_end));
               check_field("truncated", 8'(got.truncated), 8'(want.truncated));
               check_field("line_done", 8'(got.line_done), 8'(want.line_done));
               check_field("status", 8'(got.status), 8'(want.status));
               check_field("token_count", got.token_count, want.token_count);
            end
         end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ERROR: no item moved for %0d cycles", QUIET_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   initial begin : receiver
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic ls);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.char_in <= ch;
      req_ch.line_start <= ls;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic send_line_buf(input logic first_ls);
      foreach (line_buf[k]) send_char(line_buf[k], (k == 0) ? first_ls : 1'b0);
   endtask

   task automatic drain_outputs();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaited_outputs.size() != 0);
   endtask

   function automatic logic [7:0] pick_char(input cls_type c);
      logic [7:0] ch;
      case (c)
         CLS_BLANK:   ch = ($urandom_range(1) == 0) ? CH_SPACE : CH_TAB;
         CLS_COMMENT: ch = ($urandom_range(1) == 0) ? CH_BANG : CH_HASH;
         CLS_QUOTE:   ch = CH_DQUOTE;
         CLS_EOL: begin
            case ($urandom_range(2))
               0:       ch = CH_LF;
               1:       ch = CH_CR;
               default: ch = CH_NUL;
            endcase
         end
         default: begin
            do ch = 8'($urandom_range(255)); while (char_class(ch) != CLS_OTHER);
         end
      endcase
      return ch;
   endfunction

   task automatic push_word(input int n);
      repeat (n) line_buf.push_back(pick_char(CLS_OTHER));
   endtask

   // Opening quote and body; blanks and comment bytes are plain content inside quotes.
   task automatic push_quoted_body(input int n);
      int r;
      line_buf.push_back(CH_DQUOTE);
      repeat (n) begin
         r = $urandom_range(9);
         line_buf.push_back(pick_char(r < 7 ? CLS_OTHER : (r < 8 ? CLS_BLANK : CLS_COMMENT)));
      end
   endtask

   task automatic run_phase(input logic [9:0] limit, input int target, input int word_max,
                            input opening_type opening, input bit hold);
      int   first;
      int   ntok;
      int   ending;
      bit   last_word;
      logic first_ls;
      drain_outputs();
      csr_ch.valid <= 1'b1;
      csr_ch.token_limit <= limit;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      rsp_hold_req = hold;
      first = parsed_chars;
      line_buf.delete();
      if (opening == LINE_LONG_WORD) begin
         push_word(520);
         line_buf.push_back(CH_LF);
         send_line_buf(1'b1);
      end else if (opening == LINE_MANY_TOKENS) begin
         // Enough tokens in one line to drive the count into saturation.
         repeat (262) begin
            if ($urandom_range(3) != 0) begin
               line_buf.push_back(CH_DQUOTE);
               line_buf.push_back(CH_DQUOTE);
            end else begin
               push_word(1);
               line_buf.push_back(pick_char(CLS_BLANK));
            end
         end
         line_buf.push_back(CH_LF);
         send_line_buf(1'b1);
      end
      while (parsed_chars - first < target) begin
         line_buf.delete();
         if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
            first_ls = 1'($urandom_range(1));
         end else begin
            first_ls = 1'b1;
            repeat ($urandom_range(2)) line_buf.push_back(pick_char(CLS_BLANK));
            ntok = $urandom_range(5);
            last_word = 1'b0;
            for (int i = 0; i < ntok; i++) begin
               if (i > 0 && (last_word || $urandom_range(1) == 0))
                  repeat ($urandom_range(1, 2)) line_buf.push_back(pick_char(CLS_BLANK));
               if ($urandom_range(2) == 0) begin
                  push_quoted_body($urandom_range(word_max));
                  line_buf.push_back(CH_DQUOTE);
                  last_word = 1'b0;
               end else begin
                  push_word($urandom_range(1, word_max));
                  last_word = 1'b1;
               end
            end
            ending = $urandom_range(99);
            if (ending < 45) begin
               if ($urandom_range(1) == 0) line_buf.push_back(pick_char(CLS_BLANK));
               line_buf.push_back(pick_char(CLS_EOL));
            end else if (ending < 65) begin
               // Without the blank, a comment right after a word discards it.
               if ($urandom_range(1) == 0) line_buf.push_back(pick_char(CLS_BLANK));
               line_buf.push_back(pick_char(CLS_COMMENT));
            end else if (ending < 80) begin
               if (!last_word) begin
                  line_buf.push_back(pick_char(CLS_BLANK));
                  push_word($urandom_range(1, word_max));
               end
               line_buf.push_back(CH_DQUOTE);
            end else if (ending < 95) begin
               line_buf.push_back(pick_char(CLS_BLANK));
               push_quoted_body($urandom_range(word_max));
               line_buf.push_back(pick_char(CLS_EOL));
            end
            // Bytes after the end of a line are ignored until the next line start.
            repeat ($urandom_range(2)) line_buf.push_back(8'($urandom_range(255)));
         end
         send_line_buf(first_ls);
      end
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.char_in <= '0;
      req_ch.line_start <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.token_limit <= LIMIT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(SCRIPT); i++) begin
         pinned_outputs.push_back('{SCRIPT[i].typed, SCRIPT[i].want});
         send_char(SCRIPT[i].ch, SCRIPT[i].ls);
      end

      run_phase(LIMIT_RESET, 70, 12, LINE_PLAIN, 1'b1);
      run_phase(10'd1, 70, 4, LINE_PLAIN, 1'b0);
      run_phase(10'd0, 70, 3, LINE_PLAIN, 1'b0);

      send_idle_pct = 46;
      rcv_idle_pct = 25;
      run_phase(10'd3, 300, 6, LINE_MANY_TOKENS, 1'b1);
      run_phase(10'h3FF, 300, 12, LINE_LONG_WORD, 1'b0);
      run_phase(10'd7, 70, 10, LINE_PLAIN, 1'b0);

      send_idle_pct = 0;
      rcv_idle_pct = 0;
      run_phase(LIMIT_RESET, 70, 12, LINE_PLAIN, 1'b1);
      run_phase(10'($urandom_range(1, 16)), 70, 18, LINE_PLAIN, 1'b0);
      run_phase(10'd2, 70, 5, LINE_PLAIN, 1'b0);

      drain_outputs();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_outputs.size() != 0)
         log_failure($sformatf("%0d results never arrived", awaited_outputs.size()));
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
